>>> hdl/bsc_pkg.sv
package bsc_pkg;

    localparam int RAW_W     = 20;
    localparam int COEF_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 64;
    localparam int DEN_W     = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 2'd3;

    localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
    localparam logic signed [26:0] TF_OFFSET = 27'sd128000;
    localparam logic [20:0]        ADC_FULL  = 21'd1048576;
    localparam logic [11:0]        K3125     = 12'd3125;
    localparam logic [63:0]        BIAS47    = 64'd1 << 47;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coef;

    // Temperature results that ride along with the pressure computation.
    typedef struct packed {
        logic signed [14:0] tc;
        logic signed [31:0] tf;
    } t_side;

    typedef struct packed {
        logic signed [14:0] tc;
        logic        [31:0] pres;
        logic               pv;
        logic signed [31:0] tf;
    } t_result;

endpackage

>>> hdl/baro_sensor_compensation.sv
// Barometric sensor compensation, 64-bit integer formula.
// Input channel: i_valid / o_ready carries one raw temperature and one raw
// pressure reading per request. Output channel: o_valid / i_ready carries the
// saturated temperature in 0.01 degC, the pressure in Pa as Q24.8 with its
// valid flag, and the fine temperature value.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and 48-bit
// data; o_cfg_ready is always high. Write coefficients only while no request
// is in flight.
// Throughput is one request per cycle while o_ready is high. A request passes
// through multiply stages, the one bit per stage signed divider and the
// multiply stages after it to the output register that drives o_valid.
// Reset clears the coefficients and all valid bits; nothing is in flight
// afterwards. When the receiver stalls, one result moves into a skid register
// and o_ready drops on the next cycle, freezing the whole pipeline until the
// skid register drains. No request is dropped or repeated.
module baro_sensor_compensation import bsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [RAW_W-1:0]     i_raw_temperature,
    input  logic [RAW_W-1:0]     i_raw_pressure,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [14:0]   o_temperature_centi,
    output logic [31:0]          o_pressure_q24_8,
    output logic                 o_pressure_valid,
    output logic signed [31:0]   o_fine_temperature,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    logic [COEF_W-1:0] r_cfg_t;
    logic [COEF_W-1:0] r_cfg_a;
    logic [COEF_W-1:0] r_cfg_b;
    logic [COEF_W-1:0] r_cfg_c;
    t_coef             w_coef;

    logic              w_en;
    logic              w_t_vld;
    t_side             w_t_side;
    logic [RAW_W-1:0]  w_t_rp;
    logic              w_p_vld;
    t_side             w_p_side;
    logic [63:0]       w_num;
    logic [DEN_W-1:0]  w_den;
    logic              w_d_vld;
    t_side             w_d_side;
    logic [63:0]       w_quo;
    logic              w_d_pv;
    logic              w_f_vld;
    t_result           w_f_res;

    logic              r_ovld;
    t_result           r_out;
    logic              r_skv;
    t_result           r_sk;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t <= '0;
            r_cfg_a <= '0;
            r_cfg_b <= '0;
            r_cfg_c <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TEMP:    r_cfg_t <= i_cfg_data;
                CFG_PRESS_A: r_cfg_a <= i_cfg_data;
                CFG_PRESS_B: r_cfg_b <= i_cfg_data;
                CFG_PRESS_C: r_cfg_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_coef.t1 = r_cfg_t[15:0];
    assign w_coef.t2 = r_cfg_t[31:16];
    assign w_coef.t3 = r_cfg_t[47:32];
    assign w_coef.p1 = r_cfg_a[15:0];
    assign w_coef.p2 = r_cfg_a[31:16];
    assign w_coef.p3 = r_cfg_a[47:32];
    assign w_coef.p4 = r_cfg_b[15:0];
    assign w_coef.p5 = r_cfg_b[31:16];
    assign w_coef.p6 = r_cfg_b[47:32];
    assign w_coef.p7 = r_cfg_c[15:0];
    assign w_coef.p8 = r_cfg_c[31:16];
    assign w_coef.p9 = r_cfg_c[47:32];

    assign w_en    = ~r_skv;
    assign o_ready = ~r_skv;

    bsc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_raw_t (i_raw_temperature),
        .i_raw_p (i_raw_pressure),
        .i_coef  (w_coef),
        .o_vld   (w_t_vld),
        .o_side  (w_t_side),
        .o_raw_p (w_t_rp)
    );

    bsc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_t_vld),
        .i_side  (w_t_side),
        .i_raw_p (w_t_rp),
        .i_coef  (w_coef),
        .o_vld   (w_p_vld),
        .o_side  (w_p_side),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_p_vld),
        .i_side  (w_p_side),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_vld   (w_d_vld),
        .o_side  (w_d_side),
        .o_quo   (w_quo),
        .o_pv    (w_d_pv)
    );

    bsc_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_side  (w_d_side),
        .i_p     (w_quo),
        .i_pv    (w_d_pv),
        .i_coef  (w_coef),
        .o_vld   (w_f_vld),
        .o_res   (w_f_res)
    );

    // Output register plus one skid entry; the pipeline only moves while
    // the skid entry is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_skv  <= 1'b0;
        end else if (r_ovld && !i_ready) begin
            if (w_en && w_f_vld) begin
                r_skv <= 1'b1;
            end
        end else if (r_skv) begin
            r_ovld <= 1'b1;
            r_skv  <= 1'b0;
        end else begin
            r_ovld <= w_en && w_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ovld && !i_ready) begin
            if (w_en && w_f_vld) begin
                r_sk <= w_f_res;
            end
        end else if (r_skv) begin
            r_out <= r_sk;
        end else if (w_en && w_f_vld) begin
            r_out <= w_f_res;
        end
    end

    assign o_valid             = r_ovld;
    assign o_temperature_centi = r_out.tc;
    assign o_pressure_q24_8    = r_out.pres;
    assign o_pressure_valid    = r_out.pv;
    assign o_fine_temperature  = r_out.tf;

endmodule

>>> hdl/bsc_temp.sv
module bsc_temp import bsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RAW_W-1:0] i_raw_t,
    input  logic [RAW_W-1:0] i_raw_p,
    input  t_coef            i_coef,
    output logic             o_vld,
    output t_side            o_side,
    output logic [RAW_W-1:0] o_raw_p
);

    logic [3:0]              r_vld;
    logic [RAW_W-1:0]        r_rp [4];
    logic signed [34:0]      r_m1;
    logic [32:0]             r_sq;
    logic signed [23:0]      r_v1;
    logic signed [37:0]      r_m3;
    logic signed [24:0]      r_tf;
    t_side                   r_side;

    logic signed [18:0]      w_d1;
    logic signed [17:0]      w_d2;
    logic signed [35:0]      w_sq;
    logic signed [27:0]      w_t5;
    logic signed [19:0]      w_tc;
    logic signed [14:0]      n_tc;

    assign w_d1 = $signed({2'b00, i_raw_t[19:3]}) - $signed({2'b00, i_coef.t1, 1'b0});
    assign w_d2 = $signed({2'b00, i_raw_t[19:4]}) - $signed({2'b00, i_coef.t1});
    assign w_sq = w_d2 * w_d2;

    // tf * 5 + 128 as shift and add, then divide by 256.
    assign w_t5 = (28'(r_tf) <<< 2) + 28'(r_tf) + 28'sd128;
    assign w_tc = w_t5[27:8];

    always_comb begin
        if (w_tc < 20'(TEMP_MIN)) begin
            n_tc = TEMP_MIN;
        end else if (w_tc > 20'(TEMP_MAX)) begin
            n_tc = TEMP_MAX;
        end else begin
            n_tc = w_tc[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp[0]   <= i_raw_p;
            r_rp[1]   <= r_rp[0];
            r_rp[2]   <= r_rp[1];
            r_rp[3]   <= r_rp[2];
            r_m1      <= w_d1 * i_coef.t2;
            r_sq      <= w_sq[32:0];
            r_v1      <= r_m1[34:11];
            r_m3      <= $signed({1'b0, r_sq[32:12]}) * i_coef.t3;
            r_tf      <= $signed(r_v1) + $signed(r_m3[37:14]);
            r_side.tc <= n_tc;
            r_side.tf <= 32'(r_tf);
        end
    end

    assign o_vld   = r_vld[3];
    assign o_side  = r_side;
    assign o_raw_p = r_rp[3];

endmodule

>>> hdl/bsc_press.sv
module bsc_press import bsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_side              i_side,
    input  logic [RAW_W-1:0]   i_raw_p,
    input  t_coef              i_coef,
    output logic               o_vld,
    output t_side              o_side,
    output logic [63:0]        o_num,
    output logic [DEN_W-1:0]   o_den
);

    logic [6:0]          r_vld;
    t_side               r_side [7];
    logic [RAW_W-1:0]    r_rp [4];

    logic [52:0]         r_aa;
    logic signed [42:0]  r_ap5;
    logic signed [42:0]  r_ap2;
    logic signed [48:0]  r_p6l;
    logic [31:0]         r_p6h;
    logic signed [48:0]  r_p3l;
    logic [31:0]         r_p3h;
    logic signed [42:0]  r_ap5b;
    logic signed [42:0]  r_ap2b;
    logic [63:0]         r_aa6;
    logic [63:0]         r_aa3;
    logic [63:0]         r_t54;
    logic signed [42:0]  r_ap2c;
    logic [63:0]         r_bb;
    logic [63:0]         r_x;
    logic [63:0]         r_num0;
    logic [47:0]         r_xp1l;
    logic [31:0]         r_xp1h;
    logic [43:0]         r_nl;
    logic [31:0]         r_nh;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_den2;
    logic [63:0]         r_num;

    logic signed [26:0]  w_a;
    logic signed [53:0]  w_aa;
    logic signed [37:0]  w_p6h;
    logic signed [37:0]  w_p3h;
    logic [63:0]         w_aa3s;
    logic [20:0]         w_pd;
    logic [47:0]         w_xh;
    logic [43:0]         w_nh;
    logic [63:0]         w_xp1;

    assign w_a    = $signed(i_side.tf[26:0]) - TF_OFFSET;
    assign w_aa   = w_a * w_a;
    assign w_p6h  = i_coef.p6 * $signed({1'b0, r_aa[52:32]});
    assign w_p3h  = i_coef.p3 * $signed({1'b0, r_aa[52:32]});
    assign w_aa3s = {{8{r_aa3[63]}}, r_aa3[63:8]};
    assign w_pd   = ADC_FULL - {1'b0, r_rp[3]};
    assign w_xh   = r_x[63:32] * i_coef.p1;
    assign w_nh   = r_num0[63:32] * K3125;
    assign w_xp1  = {16'd0, r_xp1l} + {r_xp1h, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < 7; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_rp[0] <= i_raw_p;
            r_rp[1] <= r_rp[0];
            r_rp[2] <= r_rp[1];
            r_rp[3] <= r_rp[2];

            r_aa   <= w_aa[52:0];
            r_ap5  <= w_a * i_coef.p5;
            r_ap2  <= w_a * i_coef.p2;

            r_p6l  <= i_coef.p6 * $signed({1'b0, r_aa[31:0]});
            r_p6h  <= w_p6h[31:0];
            r_p3l  <= i_coef.p3 * $signed({1'b0, r_aa[31:0]});
            r_p3h  <= w_p3h[31:0];
            r_ap5b <= r_ap5;
            r_ap2b <= r_ap2;

            r_aa6  <= 64'(r_p6l) + {r_p6h, 32'd0};
            r_aa3  <= 64'(r_p3l) + {r_p3h, 32'd0};
            r_t54  <= (64'(r_ap5b) << 17) + (64'(i_coef.p4) << 35);
            r_ap2c <= r_ap2b;

            r_bb   <= r_aa6 + r_t54;
            r_x    <= w_aa3s + (64'(r_ap2c) << 12) + BIAS47;

            r_num0 <= ({43'd0, w_pd} << 31) - r_bb;
            r_xp1l <= r_x[31:0] * i_coef.p1;
            r_xp1h <= w_xh[31:0];

            r_nl   <= r_num0[31:0] * K3125;
            r_nh   <= w_nh[31:0];
            r_den  <= w_xp1[63:33];

            r_num  <= {20'd0, r_nl} + {r_nh, 32'd0};
            r_den2 <= r_den;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_side = r_side[6];
    assign o_num  = r_num;
    assign o_den  = r_den2;

endmodule

>>> hdl/bsc_div.sv
module bsc_div import bsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [63:0]      i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_vld,
    output t_side            o_side,
    output logic [63:0]      o_quo,
    output logic             o_pv
);

    logic [DIV_STEPS+1:0]  r_vld;
    logic [DEN_W-1:0]      r_rem  [DIV_STEPS+1];
    logic [63:0]           r_work [DIV_STEPS+1];
    logic [DEN_W-1:0]      r_dm   [DIV_STEPS+1];
    logic [DIV_STEPS:0]    r_qn;
    logic [DIV_STEPS:0]    r_z;
    t_side                 r_side [DIV_STEPS+1];
    logic [63:0]           r_quo;
    logic                  r_pv;
    t_side                 r_side_o;

    logic [63:0]           w_nmag;
    logic [DEN_W-1:0]      w_dmag;

    assign w_nmag = i_num[63] ? 64'd0 - i_num : i_num;
    assign w_dmag = i_den[DEN_W-1] ? DEN_W'(0) - i_den : i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_work[0] <= w_nmag;
            r_dm[0]   <= w_dmag;
            r_qn[0]   <= i_num[63] ^ i_den[DEN_W-1];
            r_z[0]    <= (i_den == '0);
            r_side[0] <= i_side;
        end
    end

    // One quotient bit per stage, restoring form on the magnitudes.
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [DEN_W:0]   w_sh;
        logic [DEN_W+1:0] w_df;
        logic             w_bit;

        assign w_sh  = {r_rem[k-1], r_work[k-1][63]};
        assign w_df  = {1'b0, w_sh} - {2'b00, r_dm[k-1]};
        assign w_bit = ~w_df[DEN_W+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_bit ? w_df[DEN_W-1:0] : w_sh[DEN_W-1:0];
                r_work[k] <= {r_work[k-1][62:0], w_bit};
                r_dm[k]   <= r_dm[k-1];
                r_qn[k]   <= r_qn[k-1];
                r_z[k]    <= r_z[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo    <= r_qn[DIV_STEPS] ? 64'd0 - r_work[DIV_STEPS] : r_work[DIV_STEPS];
            r_pv     <= ~r_z[DIV_STEPS];
            r_side_o <= r_side[DIV_STEPS];
        end
    end

    assign o_vld  = r_vld[DIV_STEPS+1];
    assign o_side = r_side_o;
    assign o_quo  = r_quo;
    assign o_pv   = r_pv;

endmodule

>>> hdl/bsc_final.sv
module bsc_final import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_side       i_side,
    input  logic [63:0] i_p,
    input  logic        i_pv,
    input  t_coef       i_coef,
    output logic        o_vld,
    output t_result     o_res
);

    logic [5:0]          r_vld;
    t_side               r_side [6];
    logic [5:0]          r_pv;
    logic [63:0]         r_p [4];

    logic [63:0]         r_ll;
    logic [31:0]         r_lh;
    logic signed [48:0]  r_p8l;
    logic [31:0]         r_p8h;
    logic [63:0]         r_r;
    logic [63:0]         r_e2;
    logic signed [48:0]  r_p9l;
    logic [31:0]         r_p9h;
    logic [63:0]         r_e2b;
    logic [63:0]         r_e1;
    logic [63:0]         r_e2c;
    logic [39:0]         r_s;
    logic [31:0]         r_pres;

    logic [63:0]         w_q;
    logic [63:0]         w_lh;
    logic signed [48:0]  w_p8h;
    logic signed [48:0]  w_p9h;

    assign w_q   = {{13{i_p[63]}}, i_p[63:13]};
    assign w_lh  = w_q[31:0] * w_q[63:32];
    assign w_p8h = i_coef.p8 * $signed({1'b0, i_p[63:32]});
    assign w_p9h = i_coef.p9 * $signed({1'b0, r_r[63:32]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < 6; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_pv <= {r_pv[4:0], i_pv};
            r_p[0] <= i_p;
            r_p[1] <= r_p[0];
            r_p[2] <= r_p[1];
            r_p[3] <= r_p[2];

            // q * q modulo 2^64 from the two halves of q.
            r_ll  <= w_q[31:0] * w_q[31:0];
            r_lh  <= w_lh[31:0];
            r_p8l <= i_coef.p8 * $signed({1'b0, i_p[31:0]});
            r_p8h <= w_p8h[31:0];

            r_r   <= r_ll + {r_lh[30:0], 33'd0};
            r_e2  <= 64'(r_p8l) + {r_p8h, 32'd0};

            r_p9l <= i_coef.p9 * $signed({1'b0, r_r[31:0]});
            r_p9h <= w_p9h[31:0];
            r_e2b <= r_e2;

            r_e1  <= 64'(r_p9l) + {r_p9h, 32'd0};
            r_e2c <= r_e2b;

            // Only bits 39:8 of the sum reach the output.
            r_s   <= r_p[3][39:0] + {r_e1[63], r_e1[63:25]} + r_e2c[58:19];

            r_pres <= r_pv[4] ? r_s[39:8] + {{12{i_coef.p7[15]}}, i_coef.p7, 4'd0} : 32'd0;
        end
    end

    assign o_vld      = r_vld[5];
    assign o_res.tc   = r_side[5].tc;
    assign o_res.tf   = r_side[5].tf;
    assign o_res.pv   = r_pv[5];
    assign o_res.pres = r_pres;

endmodule

>>> hdl/bsc_checker.sv
module bsc_checker import bsc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic signed [14:0]   o_temperature_centi,
    input logic [31:0]          o_pressure_q24_8,
    input logic                 o_pressure_valid,
    input logic signed [31:0]   o_fine_temperature
);

    // A stalled result stays presented, with its pressure and fine temperature unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pressure_q24_8)
            && $stable(o_fine_temperature))
        else $error("stalled result changed");

    // A zero divisor must force the pressure to zero.
    a_pres_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pressure_valid |-> o_pressure_q24_8 == 32'd0)
        else $error("pressure not zero with divisor zero");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_temperature_centi >= TEMP_MIN && o_temperature_centi <= TEMP_MAX)
        else $error("temperature outside saturation range");

    // Input backpressure only appears after the output was stalled.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(o_valid && !i_ready))
        else $error("input stalled without output stall");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);
